// File: src/tbp_pkg.sv
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types and constants for the two-button short/long press detector.
// ----------------------------------------------------------------------------
package tbp_pkg;

    // hold counters stop here
    localparam logic [7:0]  HOLD_SAT    = 8'd250;
    // mode word: 1000 <-> 2000 by XOR
    localparam logic [10:0] MODE_TOGGLE = 11'd1080;
    localparam logic [10:0] MODE_RESET  = 11'd1000;

    // key_bits positions
    localparam int unsigned KEY_A_BIT = 0;
    localparam int unsigned KEY_B_BIT = 1;

    // config register reset values
    localparam logic [7:0] LONG_PRESS_RST = 8'd200;
    localparam logic [7:0] SHORT_MIN_RST  = 8'd2;
    localparam logic [7:0] SHORT_MAX_RST  = 8'd100;
    localparam logic [3:0] BEEP_TICKS_RST = 4'd5;

    typedef enum logic [2:0] {
        CFG_LONG_PRESS   = 3'd0,
        CFG_SHORT_MIN    = 3'd1,
        CFG_SHORT_MAX    = 3'd2,
        CFG_BEEP_TICKS   = 3'd3,
        CFG_DISP_PRESENT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic button_a_down;
        logic button_b_down;
        logic window_lock;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  key_bits;
        logic        pair_request;
        logic        calibrate_request;
        logic [1:0]  window_index;
        logic [10:0] mode_word;
        logic        beeper_on;
    } t_out_word;

    typedef struct packed {
        t_cfg_idx   index;
        logic [7:0] wdata;
    } t_cfg_word;

endpackage

// File: src/tbp_if.sv
// ----------------------------------------------------------------------------
// tbp_if
// Valid/ready channels of the press detector: tick in, result out, config.
// ----------------------------------------------------------------------------
interface tbp_in_if import tbp_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tbp_out_if import tbp_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tbp_cfg_if import tbp_pkg::*;;
    logic      valid;
    logic      ready;
    t_cfg_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/two_button_short_long_press.sv
// ----------------------------------------------------------------------------
// two_button_short_long_press
// Per-tick button scanner: hold counters, long-press pulses, short-press
// window/mode actions and a beeper pulse timer.
// ----------------------------------------------------------------------------
// Path: an accepted tick word goes to the input register, then to the
//   result register, which holds it until the output handshake.
// Throughput: one tick word per cycle while the result side takes words;
//   all state updates in one pass.
// Reset (i_rst_n low, synchronous): both stages empty, counters and beeper
//   cleared, window 0, mode 1000, config registers back to defaults.
// ----------------------------------------------------------------------------
module two_button_short_long_press import tbp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tbp_in_if.sink        i_in,
    tbp_out_if.source     o_out,
    tbp_cfg_if.sink       i_cfg
);

    // ---------------- config registers ----------------
    // User must write only while idle (not enforced), so no shadowing needed.
    logic [7:0] r_long_press;
    logic [7:0] r_short_min;
    logic [7:0] r_short_max;
    logic [3:0] r_beep_ticks;
    logic       r_disp_present;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press   <= LONG_PRESS_RST;
            r_short_min    <= SHORT_MIN_RST;
            r_short_max    <= SHORT_MAX_RST;
            r_beep_ticks   <= BEEP_TICKS_RST;
            r_disp_present <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_LONG_PRESS:   r_long_press   <= i_cfg.data.wdata;
                CFG_SHORT_MIN:    r_short_min    <= i_cfg.data.wdata;
                CFG_SHORT_MAX:    r_short_max    <= i_cfg.data.wdata;
                CFG_BEEP_TICKS:   r_beep_ticks   <= i_cfg.data.wdata[3:0];
                CFG_DISP_PRESENT: r_disp_present <= i_cfg.data.wdata[0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Input register feeds the update logic; the result register holds the
    // finished word until taken. The input stage refills whenever its word
    // moves on, so a stalled result blocks a new tick only once the input
    // register holds a word as well.
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    logic      advance;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // ---------------- tick state ----------------
    logic [7:0]  r_hold_a, n_hold_a;
    logic [7:0]  r_hold_b, n_hold_b;
    logic        r_beep_pending, n_beep_pending;
    logic [4:0]  r_beep_count, n_beep_count;
    logic        r_beeper, n_beeper;
    logic [1:0]  r_window, n_window;
    logic [10:0] r_mode, n_mode;
    logic        n_pair;
    logic        n_calib;

    // incremented counts; 250 + 1 still fits in 8 bits
    logic [7:0] inc_a;
    logic [7:0] inc_b;
    logic       short_a;
    logic       short_b;
    logic [1:0] win_step;

    always_comb begin
        inc_a    = r_hold_a + 8'd1;
        inc_b    = r_hold_b + 8'd1;
        short_a  = (r_hold_a >= r_short_min) && (r_hold_a <= r_short_max);
        short_b  = (r_hold_b >= r_short_min) && (r_hold_b <= r_short_max);
        win_step = r_window + 2'd1;

        n_hold_a       = r_hold_a;
        n_hold_b       = r_hold_b;
        n_beep_pending = r_beep_pending;
        n_beep_count   = r_beep_count;
        n_beeper       = r_beeper;
        n_window       = r_window;
        n_mode         = r_mode;
        n_pair         = 1'b0;
        n_calib        = 1'b0;

        // button A: hold count / release
        if (r_in.button_a_down) begin
            n_pair   = (inc_a == r_long_press);
            n_hold_a = (inc_a >= HOLD_SAT) ? HOLD_SAT : inc_a;
        end else begin
            n_hold_a = '0;
            if (short_a && r_disp_present) begin
                n_beep_pending = 1'b1;
                // wrap after 2, or park at 0 when locked
                n_window = (win_step == 2'd3 || r_in.window_lock) ? 2'd0 : win_step;
            end
        end

        // button B: hold count / release
        if (r_in.button_b_down) begin
            n_calib  = (inc_b == r_long_press);
            n_hold_b = (inc_b >= HOLD_SAT) ? HOLD_SAT : inc_b;
        end else begin
            n_hold_b = '0;
            if (short_b) begin
                n_mode         = r_mode ^ MODE_TOGGLE;
                n_beep_pending = 1'b1;
            end
        end

        // beeper pulse timer; zero length turns on and off in one tick
        if (n_beep_pending) begin
            n_beeper     = 1'b1;
            n_beep_count = r_beep_count + 5'd1;
            if (n_beep_count > {1'b0, r_beep_ticks}) begin
                n_beep_count   = '0;
                n_beep_pending = 1'b0;
                n_beeper       = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_a       <= '0;
            r_hold_b       <= '0;
            r_beep_pending <= 1'b0;
            r_beep_count   <= '0;
            r_beeper       <= 1'b0;
            r_window       <= '0;
            r_mode         <= MODE_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            if (advance) begin
                r_hold_a       <= n_hold_a;
                r_hold_b       <= n_hold_b;
                r_beep_pending <= n_beep_pending;
                r_beep_count   <= n_beep_count;
                r_beeper       <= n_beeper;
                r_window       <= n_window;
                r_mode         <= n_mode;
                r_out_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word, captured with the state update
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.key_bits[KEY_A_BIT] <= r_in.button_a_down;
            r_out.key_bits[KEY_B_BIT] <= r_in.button_b_down;
            r_out.pair_request        <= n_pair;
            r_out.calibrate_request   <= n_calib;
            r_out.window_index        <= n_window;
            r_out.mode_word           <= n_mode;
            r_out.beeper_on           <= n_beeper;
        end
    end

    // ---------------- assertions ----------------
    // a held button always leaves a nonzero count behind
    a_hold_a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.button_a_down |=> r_hold_a != 8'd0)
        else $error("hold count A did not advance while pressed");

    // a released button clears its count
    a_hold_b_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in.button_b_down |=> r_hold_b == 8'd0)
        else $error("hold count B not cleared on release");

    // beep timer and beeper only run while a beep is pending
    a_beep_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beep_count != 5'd0) || r_beeper |-> r_beep_pending)
        else $error("beeper active with no pending beep");

    // a result word leaves the pipe only through a handshake or stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result word changed");

endmodule

// File: tb/tbp_press_checker.sv
// ----------------------------------------------------------------------------
// tbp_press_checker
// Watches the tick, result and config channels of the press detector, keeps
// its own copy of the scan state and compares every result word in order.
// ----------------------------------------------------------------------------
module tbp_press_checker import tbp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    tbp_in_if    tick_ch,
    tbp_out_if   res_ch,
    tbp_cfg_if   cfg_ch,
    output int   o_err_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // config copy
    logic [7:0]  long_press;
    logic [7:0]  short_min;
    logic [7:0]  short_max;
    logic [3:0]  beep_len;
    logic        disp_on;

    // scan state copy
    logic [7:0]  hold_a;
    logic [7:0]  hold_b;
    logic        beep_pend;
    logic [4:0]  beep_cnt;
    logic        beep_lvl;
    logic [1:0]  win;
    logic [10:0] mode;

    t_out_word   scan_results_q[$];
    int          mismatches = 0;
    int          waiting    = 0;

    assign o_err_count = mismatches;
    assign o_pending   = waiting;

    // count one more held tick; true on the tick that hits the long threshold
    function automatic logic hold_step(input logic [7:0] cnt, output logic [7:0] nxt);
        logic [8:0] n;
        n   = {1'b0, cnt} + 9'd1;
        nxt = (n >= {1'b0, HOLD_SAT}) ? HOLD_SAT : n[7:0];
        return n == {1'b0, long_press};
    endfunction

    function automatic logic is_short(input logic [7:0] cnt);
        return cnt >= short_min && cnt <= short_max;
    endfunction

    function automatic t_out_word predict_scan(input t_in_word w);
        t_out_word  r;
        logic       pair;
        logic       calib;
        logic [7:0] nxt;
        pair  = 1'b0;
        calib = 1'b0;

        if (w.button_a_down) begin
            pair   = hold_step(hold_a, nxt);
            hold_a = nxt;
        end else begin
            if (is_short(hold_a) && disp_on) begin
                beep_pend = 1'b1;
                win       = win + 2'd1;
                if (win == 2'd3 || w.window_lock)
                    win = 2'd0;
            end
            hold_a = 8'd0;
        end

        if (w.button_b_down) begin
            calib  = hold_step(hold_b, nxt);
            hold_b = nxt;
        end else begin
            if (is_short(hold_b)) begin
                mode      = mode ^ MODE_TOGGLE;
                beep_pend = 1'b1;
            end
            hold_b = 8'd0;
        end

        if (beep_pend) begin
            beep_lvl = 1'b1;
            beep_cnt = beep_cnt + 5'd1;
            if (beep_cnt > {1'b0, beep_len}) begin
                beep_cnt  = 5'd0;
                beep_pend = 1'b0;
                beep_lvl  = 1'b0;
            end
        end

        r                     = '0;
        r.key_bits[KEY_A_BIT] = w.button_a_down;
        r.key_bits[KEY_B_BIT] = w.button_b_down;
        r.pair_request        = pair;
        r.calibrate_request   = calib;
        r.window_index        = win;
        r.mode_word           = mode;
        r.beeper_on           = beep_lvl;
        return r;
    endfunction

    function automatic void cmp_field(input string fld, input logic [10:0] want,
                                      input logic [10:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, fld, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            long_press = LONG_PRESS_RST;
            short_min  = SHORT_MIN_RST;
            short_max  = SHORT_MAX_RST;
            beep_len   = BEEP_TICKS_RST;
            disp_on    = 1'b1;
            hold_a     = 8'd0;
            hold_b     = 8'd0;
            beep_pend  = 1'b0;
            beep_cnt   = 5'd0;
            beep_lvl   = 1'b0;
            win        = 2'd0;
            mode       = MODE_RESET;
            scan_results_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.data.index)
                    CFG_LONG_PRESS:   long_press = cfg_ch.data.wdata;
                    CFG_SHORT_MIN:    short_min  = cfg_ch.data.wdata;
                    CFG_SHORT_MAX:    short_max  = cfg_ch.data.wdata;
                    CFG_BEEP_TICKS:   beep_len   = cfg_ch.data.wdata[3:0];
                    CFG_DISP_PRESENT: disp_on    = cfg_ch.data.wdata[0];
                    default: ;
                endcase
            end

            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                if (scan_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word expected none, got %h", $time, got);
                end else begin
                    want = scan_results_q.pop_front();
                    cmp_field("key_bits", 11'(want.key_bits), 11'(got.key_bits));
                    cmp_field("pair_request", 11'(want.pair_request),
                              11'(got.pair_request));
                    cmp_field("calibrate_request", 11'(want.calibrate_request),
                              11'(got.calibrate_request));
                    cmp_field("window_index", 11'(want.window_index),
                              11'(got.window_index));
                    cmp_field("mode_word", want.mode_word, got.mode_word);
                    cmp_field("beeper_on", 11'(want.beeper_on), 11'(got.beeper_on));
                end
            end

            if (tick_ch.valid && tick_ch.ready)
                scan_results_q.push_back(predict_scan(tick_ch.data));
        end
        waiting = scan_results_q.size();
    end

endmodule

// File: tb/tb_two_button_short_long_press.sv
// ----------------------------------------------------------------------------
// tb_two_button_short_long_press
// Drives scan ticks and config writes into the press detector, stalls the
// result side at random, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb_two_button_short_long_press import tbp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tbp_in_if  tick_ch ();
    tbp_out_if res_ch ();
    tbp_cfg_if cfg_ch ();

    int err_count;
    int pending;

    // no random gaps on either side while set
    bit quiet = 1'b0;

    // thresholds as last written, steer the hold lengths
    int long_sh = LONG_PRESS_RST;
    int min_sh  = SHORT_MIN_RST;
    int max_sh  = SHORT_MAX_RST;

    // per-button sequence state: ticks left at the current level
    int   a_left = 0;
    logic a_down = 1'b1;
    int   b_left = 0;
    logic b_down = 1'b1;

    // directed script, bits are {A down, B down, lock}
    logic [2:0] scan_script [24] = '{
        3'b000,                          // idle tick
        3'b100, 3'b000,                  // A tap one tick: too short
        3'b100, 3'b100, 3'b000,          // A short: window 1, beep starts
        3'b010, 3'b010, 3'b010, 3'b000,  // B short while beeping: mode 2000
        3'b100, 3'b100, 3'b001,          // A short with lock: window back to 0
        3'b110, 3'b110, 3'b110, 3'b000,  // both released together
        3'b111,                          // every input bit high
        3'b100, 3'b100, 3'b000,          // window 2
        3'b100, 3'b100, 3'b000           // wrap to 0
    };

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    two_button_short_long_press uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    tbp_press_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .tick_ch     (tick_ch),
        .res_ch      (res_ch),
        .cfg_ch      (cfg_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // result side: drop ready at random with a 6 percent chance, never while quiet
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= quiet || ($urandom_range(0, 99) >= 6);
        end
    end

    // hold lengths cluster on the thresholds so every boundary gets hit;
    // now and then a hold runs into the 250 saturation
    function automatic int pick_hold();
        int len;
        case ($urandom_range(0, 23))
            0:       len = min_sh - 1;
            1:       len = min_sh;
            2:       len = max_sh;
            3:       len = max_sh + 1;
            4:       len = long_sh - 1;
            5:       len = long_sh;
            6:       len = long_sh + 1;
            7:       len = $urandom_range(245, 260);
            default: len = $urandom_range(1, 8);
        endcase
        if (len < 1)
            len = 1;
        if (len > 260)
            len = 260;
        return len;
    endfunction

    // alternate press and release; the release gap is where short presses count
    function automatic void next_level(inout int left, inout logic down);
        if (left == 0) begin
            down = !down;
            left = down ? pick_hold() : $urandom_range(1, 4);
        end
        left--;
    endfunction

    task automatic send_tick(input t_in_word w);
        while (!quiet && $urandom_range(0, 99) < 6) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= w;
        do @(posedge i_clk); while (!tick_ch.ready);
    endtask

    // hold the sender until every result word is back, then let the
    // two-stage pipe settle
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // valid stays high across back-to-back writes; set_config lowers it
    task automatic put_reg(input t_cfg_idx idx, input logic [7:0] v);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.wdata <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // narrow registers get junk in the unused upper bits of the write data
    task automatic set_config(input int lp, input int smin, input int smax,
                              input int bt, input int dp);
        put_reg(CFG_LONG_PRESS, 8'(lp));
        put_reg(CFG_SHORT_MIN, 8'(smin));
        put_reg(CFG_SHORT_MAX, 8'(smax));
        put_reg(CFG_BEEP_TICKS, {4'($urandom), 4'(bt)});
        put_reg(CFG_DISP_PRESENT, {7'($urandom), 1'(dp)});
        cfg_ch.valid <= 1'b0;
        long_sh = lp;
        min_sh  = smin;
        max_sh  = smax;
        @(posedge i_clk);
    endtask

    // mostly well-formed press/release sequences, a little noise on top
    task automatic run_phase(input int n_ticks, input bit calm, input bit mid_pause);
        t_in_word w;
        quiet = calm;
        for (int k = 0; k < n_ticks; k++) begin
            if (mid_pause && k == n_ticks / 2)
                drain_results();
            next_level(a_left, a_down);
            next_level(b_left, b_down);
            w.button_a_down = a_down;
            w.button_b_down = b_down;
            w.window_lock   = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0) begin
                w.button_a_down = 1'($urandom);
                w.button_b_down = 1'($urandom);
            end
            send_tick(w);
        end
        drain_results();
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        tick_ch.valid     <= 1'b0;
        tick_ch.data      <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data.index <= CFG_LONG_PRESS;
        cfg_ch.data.wdata <= 8'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, at reset config
        foreach (scan_script[i])
            send_tick(t_in_word'(scan_script[i]));
        drain_results();

        // small thresholds: many long-press pulses and short presses
        set_config(4, 1, 3, 3, 1);
        run_phase(250, 1'b0, 1'b0);

        // low extremes: pulse on first held tick, zero-length beep
        set_config(1, 1, 1, 0, 1);
        run_phase(250, 1'b0, 1'b0);

        // high extremes: long press right at saturation, longest beep
        set_config(250, 250, 250, 15, 1);
        run_phase(500, 1'b0, 1'b0);

        // threshold 0 never pulses, empty short range, no display
        set_config(0, 5, 2, 7, 0);
        run_phase(200, 1'b0, 1'b0);

        // threshold above saturation, widest short range, no gaps anywhere
        set_config(255, 1, 250, 15, 1);
        run_phase(300, 1'b1, 1'b0);

        // sender holds off mid-phase until all results are in
        set_config(10, 3, 12, 2, 1);
        run_phase(250, 1'b0, 1'b1);

        // anything goes, short minimum of 0 included
        set_config($urandom_range(0, 255), $urandom_range(0, 12),
                   $urandom_range(0, 40), $urandom_range(0, 15),
                   $urandom_range(0, 1));
        run_phase(150, 1'b0, 1'b0);

        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_two_button_short_long_press: done, clean");
        end else begin
            $display("tb_two_button_short_long_press: done, errors");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("tb_two_button_short_long_press: done, errors");
        $finish;
    end

endmodule

// File: sim.f
src/tbp_pkg.sv
src/tbp_if.sv
src/two_button_short_long_press.sv
tb/tbp_press_checker.sv
tb/tb_two_button_short_long_press.sv
